>>> hdl/phu_pkg.sv
package phu_pkg;

    localparam int PTR_W  = 64;
    localparam int HASH_W = 32;
    localparam int HALF_W = 32;
    localparam int MODE_W = 3;
    localparam int BYTE_W = 8;
    localparam int CRC_STAGES = PTR_W / BYTE_W;

    localparam logic [HASH_W-1:0] CRC32C_POLY = 32'h82F6_3B78;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 3'd0,
        MODE_XOR    = 3'd1,
        MODE_CRC    = 3'd2,
        MODE_MULADD = 3'd3,
        MODE_MUL64  = 3'd4,
        MODE_MUL128 = 3'd5
    } mode_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [PTR_W-1:0]    ptr;
        logic [HASH_W-1:0]   addend;
        logic [2*HALF_W-1:0] p00;
        logic [2*HALF_W-1:0] p01;
        logic [2*HALF_W-1:0] p10;
        logic [2*HALF_W-1:0] p11;
    } prod_word_t;

    typedef struct packed {
        logic              crc_en;
        logic [HASH_W-1:0] crc;
        logic [PTR_W-1:0]  data;
    } crc_word_t;

    function automatic logic [HASH_W-1:0] crc32c_byte(
        input logic [HASH_W-1:0] crc_in,
        input logic [BYTE_W-1:0] data_byte
    );
        logic [HASH_W-1:0] crc;
        logic fb;
        crc = crc_in;
        for (int i = 0; i < BYTE_W; i++) begin
            fb  = crc[0] ^ data_byte[i];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ CRC32C_POLY;
            end
        end
        return crc;
    endfunction

endpackage

>>> hdl/pointer_hash_unit.sv
// pointer_hash_unit: ten register stages, one partial-product stage, one combine stage
// and eight byte-wide crc stages, the last of which is the output register
// path: each word is registered in the product, combine and crc stages in order; a stall holds it in place
// throughput: one word per cycle while m_ready is high; each stage holds a word and fills any bubble ahead of it
// reset: synchronous active-low aresetn clears every stage valid and sets bloom_base to 0
module pointer_hash_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [phu_pkg::PTR_W-1:0]   cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [phu_pkg::MODE_W-1:0]  s_mode,
    input  logic [phu_pkg::PTR_W-1:0]   s_pointer_value,
    input  logic [phu_pkg::PTR_W-1:0]   s_multiplier,
    input  logic [phu_pkg::HASH_W-1:0]  s_addend_or_seed,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [phu_pkg::HASH_W-1:0]  m_hash_value
);
    import phu_pkg::*;

    logic [PTR_W-1:0] bloom_base_reg;
    prod_word_t       prod_word;
    logic             prod_valid;
    logic             prod_ready;
    crc_word_t        crc_word  [0:CRC_STAGES];
    logic             crc_valid [0:CRC_STAGES];
    logic             crc_ready [0:CRC_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bloom_base_reg <= '0;
        end else if (cfg_we) begin
            bloom_base_reg <= cfg_wdata;
        end
    end

    phu_mul_stage u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_mode   (s_mode),
        .in_ptr    (s_pointer_value),
        .in_mul    (s_multiplier),
        .in_addend (s_addend_or_seed),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_word  (prod_word)
    );

    phu_combine_stage u_combine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .bloom_base (bloom_base_reg),
        .in_valid   (prod_valid),
        .in_ready   (prod_ready),
        .in_word    (prod_word),
        .out_valid  (crc_valid[0]),
        .out_ready  (crc_ready[0]),
        .out_word   (crc_word[0])
    );

    for (genvar k = 0; k < CRC_STAGES; k++) begin : g_crc
        phu_crc_stage u_crc (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (crc_valid[k]),
            .in_ready  (crc_ready[k]),
            .in_word   (crc_word[k]),
            .out_valid (crc_valid[k+1]),
            .out_ready (crc_ready[k+1]),
            .out_word  (crc_word[k+1])
        );
    end

    assign crc_ready[CRC_STAGES] = m_ready;
    assign m_valid      = crc_valid[CRC_STAGES];
    assign m_hash_value = crc_word[CRC_STAGES].crc;

`ifndef NO_ASSERTIONS
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> prod_valid)
        else $error("accepted word did not reach the product stage");

    a_prod_held: assert property (@(posedge aclk) disable iff (!aresetn)
        prod_valid && !prod_ready |=> prod_valid && $stable(prod_word))
        else $error("stalled product word lost or changed");

    a_out_from_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(crc_valid[CRC_STAGES-1]))
        else $error("result appeared without a word in the last crc stage");

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hash_value))
        else $error("stalled result lost or changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !prod_valid)
        else $error("pipeline not empty after reset");
`endif

endmodule

>>> hdl/phu_mul_stage.sv
module phu_mul_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [phu_pkg::MODE_W-1:0]  in_mode,
    input  logic [phu_pkg::PTR_W-1:0]   in_ptr,
    input  logic [phu_pkg::PTR_W-1:0]   in_mul,
    input  logic [phu_pkg::HASH_W-1:0]  in_addend,
    output logic                        out_valid,
    input  logic                        out_ready,
    output phu_pkg::prod_word_t         out_word
);
    import phu_pkg::*;

    logic       valid_reg;
    prod_word_t word_reg;
    prod_word_t word_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        word_next.mode   = in_mode;
        word_next.ptr    = in_ptr;
        word_next.addend = in_addend;
        word_next.p00    = (2*HALF_W)'(in_ptr[HALF_W-1:0])
                         * (2*HALF_W)'(in_mul[HALF_W-1:0]);
        word_next.p01    = (2*HALF_W)'(in_ptr[HALF_W-1:0])
                         * (2*HALF_W)'(in_mul[PTR_W-1:HALF_W]);
        word_next.p10    = (2*HALF_W)'(in_ptr[PTR_W-1:HALF_W])
                         * (2*HALF_W)'(in_mul[HALF_W-1:0]);
        word_next.p11    = (2*HALF_W)'(in_ptr[PTR_W-1:HALF_W])
                         * (2*HALF_W)'(in_mul[PTR_W-1:HALF_W]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> hdl/phu_combine_stage.sv
module phu_combine_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [phu_pkg::PTR_W-1:0]  bloom_base,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  phu_pkg::prod_word_t        in_word,
    output logic                       out_valid,
    input  logic                       out_ready,
    output phu_pkg::crc_word_t         out_word
);
    import phu_pkg::*;

    logic              valid_reg;
    crc_word_t         word_reg;
    crc_word_t         word_next;
    logic [HALF_W+1:0] mid;
    logic [HASH_W-1:0] hi32;
    logic [PTR_W-1:0]  lo;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        mid  = {2'b00, in_word.p00[2*HALF_W-1:HALF_W]}
             + {2'b00, in_word.p01[HALF_W-1:0]}
             + {2'b00, in_word.p10[HALF_W-1:0]};
        lo   = {mid[HALF_W-1:0], in_word.p00[HALF_W-1:0]};
        hi32 = in_word.p11[HALF_W-1:0]
             + in_word.p01[2*HALF_W-1:HALF_W]
             + in_word.p10[2*HALF_W-1:HALF_W]
             + {{(HASH_W-2){1'b0}}, mid[HALF_W+1:HALF_W]};

        word_next.crc_en = 1'b0;
        word_next.crc    = '0;
        word_next.data   = '0;
        case (in_word.mode)
            MODE_ADD: begin
                word_next.crc = in_word.ptr[HASH_W-1:0] + in_word.addend;
            end
            MODE_XOR: begin
                word_next.crc = in_word.ptr[HASH_W-1:0] ^ in_word.addend;
            end
            MODE_CRC: begin
                word_next.crc_en = 1'b1;
                word_next.crc    = in_word.addend;
                word_next.data   = in_word.ptr;
            end
            MODE_MULADD: begin
                word_next.crc = in_word.p00[HASH_W-1:0] + in_word.addend;
            end
            MODE_MUL64: begin
                word_next.crc_en = 1'b1;
                word_next.crc    = in_word.p00[HASH_W-1:0];
                word_next.data   = bloom_base;
            end
            MODE_MUL128: begin
                word_next.crc_en = 1'b1;
                word_next.crc    = hi32;
                word_next.data   = lo;
            end
            default: begin
                word_next.crc = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> hdl/phu_crc_stage.sv
module phu_crc_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  phu_pkg::crc_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output phu_pkg::crc_word_t  out_word
);
    import phu_pkg::*;

    logic      valid_reg;
    crc_word_t word_reg;
    crc_word_t word_next;

    assign in_ready = !valid_reg || out_ready;

    // one byte of the data word per stage, low byte first
    always_comb begin
        word_next.crc_en = in_word.crc_en;
        word_next.data   = {{BYTE_W{1'b0}}, in_word.data[PTR_W-1:BYTE_W]};
        if (in_word.crc_en) begin
            word_next.crc = crc32c_byte(in_word.crc, in_word.data[BYTE_W-1:0]);
        end else begin
            word_next.crc = in_word.crc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule
